// ===== src/psp_pkg.sv =====
// Shared types and constants for the point set proximity detector.
package psp_pkg;

    localparam int unsigned COORD_BITS = 16;
    localparam int unsigned DIST_BITS = 34;
    localparam int unsigned MAG_BITS = COORD_BITS + 1;
    localparam int unsigned SQ_BITS = 2 * MAG_BITS;
    localparam int unsigned SUM_BITS =
        (SQ_BITS + 2 > DIST_BITS + 1) ? SQ_BITS + 2 : DIST_BITS + 1;

    localparam int unsigned MAX_REF_DEFAULT = 1024;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
    localparam logic [DIST_BITS-1:0] TOUCH_LIMIT_RESET = DIST_BITS'(40000);

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = 1;
    localparam int unsigned QUEUE_CNT_W = 2;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_LOAD,
        CMD_QUERY
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic                         final_query;
    } in_item_t;

    typedef struct packed {
        logic                 touching;
        logic [DIST_BITS-1:0] nearest_squared;
        logic                 set_empty;
        logic                 store_overflowed;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    typedef struct packed {
        cmd_t   cmd;
        point_t point;
        logic   final_query;
    } cmd_item_t;

endpackage

// ===== src/psp_front.sv =====
// Request decoder and two-entry command queue feeding the search engine.
module psp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  psp_pkg::in_item_t in_item,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output psp_pkg::cmd_item_t cmd_item
);
    import psp_pkg::*;

    cmd_item_t              queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] fill_reg, fill_next;
    cmd_item_t              decoded;
    logic                   is_cmd;
    logic                   push;
    logic                   pop;

    always_comb
    begin
        decoded.point.x = in_item.coord_x;
        decoded.point.y = in_item.coord_y;
        decoded.point.z = in_item.coord_z;
        decoded.final_query = in_item.final_query;
        decoded.cmd = CMD_CLEAR;
        is_cmd = 1'b1;
        unique case (in_item.operation)
            OP_CLEAR: decoded.cmd = CMD_CLEAR;
            OP_LOAD:  decoded.cmd = CMD_LOAD;
            OP_QUERY: decoded.cmd = CMD_QUERY;
            default:  is_cmd = 1'b0;
        endcase
    end

    assign in_ready  = (fill_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd_item  = queue_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready && is_cmd;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ===== src/psp_back.sv =====
// Reference store, distance pipeline, running minimum and result register.
module psp_back #(
    parameter int unsigned MAX_REFERENCE_POINTS = psp_pkg::MAX_REF_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  psp_pkg::cmd_item_t               cmd_item,
    input  logic [psp_pkg::DIST_BITS-1:0]    touch_limit,
    output logic                             out_valid,
    input  logic                             out_ready,
    output psp_pkg::out_item_t               out_item
);
    import psp_pkg::*;

    localparam int unsigned ADDR_W =
        (MAX_REFERENCE_POINTS > 1) ? $clog2(MAX_REFERENCE_POINTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_REFERENCE_POINTS + 1);

    point_t               store [MAX_REFERENCE_POINTS];
    point_t               rd_data_reg;
    logic                 rd_valid_reg;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 overflow_reg, overflow_next;
    logic [DIST_BITS-1:0] min_reg, min_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg;

    point_t               query_reg;
    logic                 final_reg;
    logic                 take_query;
    logic                 load_result;

    logic                 mem_we;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_addr;

    logic [MAG_BITS-1:0]  mag_reg [3];
    logic                 mag_valid_reg;
    logic [SQ_BITS-1:0]   sq_reg [3];
    logic                 sq_valid_reg;

    logic [SUM_BITS-1:0]  dist_sum;
    logic [DIST_BITS-1:0] dist_sat;
    logic                 empty_set;
    logic                 last_idx;
    out_item_t            result;

    function automatic logic [MAG_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [MAG_BITS-1:0] d;
        d = MAG_BITS'(a) - MAG_BITS'(b);
        abs_diff = d[MAG_BITS-1] ? MAG_BITS'(-d) : MAG_BITS'(d);
    endfunction

    assign dist_sum = SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[2]);
    assign dist_sat = (dist_sum > SUM_BITS'(DIST_MAX)) ? DIST_MAX
                                                       : dist_sum[DIST_BITS-1:0];
    assign empty_set = (count_reg == '0);
    assign last_idx  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        result.set_empty        = empty_set;
        result.store_overflowed = overflow_reg;
        result.nearest_squared  = empty_set ? DIST_MAX : min_reg;
        result.touching         = !empty_set && (min_reg <= touch_limit);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        min_next       = min_reg;
        cmd_ready      = 1'b0;
        take_query     = 1'b0;
        load_result    = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (sq_valid_reg && (dist_sat < min_reg))
        begin
            min_next = dist_sat;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    unique case (cmd_item.cmd)
                        CMD_CLEAR:
                        begin
                            count_next    = '0;
                            overflow_next = 1'b0;
                            min_next      = DIST_MAX;
                        end
                        CMD_LOAD:
                        begin
                            if (count_reg < CNT_W'(MAX_REFERENCE_POINTS))
                            begin
                                mem_we     = 1'b1;
                                mem_addr   = count_reg[ADDR_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            take_query = 1'b1;
                            idx_next   = '0;
                            if (!empty_set)
                            begin
                                state_next = ST_SCAN;
                            end
                            else if (cmd_item.final_query)
                            begin
                                state_next = ST_REPORT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                mem_re = 1'b1;
                idx_next = idx_reg + ADDR_W'(1);
                if (last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !mag_valid_reg && !sq_valid_reg)
                begin
                    state_next = final_reg ? ST_REPORT : ST_IDLE;
                end
            end
            ST_REPORT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_result    = 1'b1;
                    out_valid_next = 1'b1;
                    min_next       = DIST_MAX;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            min_reg       <= DIST_MAX;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            mag_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            min_reg       <= min_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            rd_valid_reg  <= mem_re;
            mag_valid_reg <= rd_valid_reg;
            sq_valid_reg  <= mag_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_addr] <= cmd_item.point;
        end
        if (mem_re)
        begin
            rd_data_reg <= store[mem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_query)
        begin
            query_reg <= cmd_item.point;
            final_reg <= cmd_item.final_query;
        end
        mag_reg[0] <= abs_diff(query_reg.x, rd_data_reg.x);
        mag_reg[1] <= abs_diff(query_reg.y, rd_data_reg.y);
        mag_reg[2] <= abs_diff(query_reg.z, rd_data_reg.z);
        sq_reg[0]  <= SQ_BITS'(mag_reg[0]) * SQ_BITS'(mag_reg[0]);
        sq_reg[1]  <= SQ_BITS'(mag_reg[1]) * SQ_BITS'(mag_reg[1]);
        sq_reg[2]  <= SQ_BITS'(mag_reg[2]) * SQ_BITS'(mag_reg[2]);
        if (load_result)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== src/point_set_proximity_detector.sv =====
// Top level of the point set proximity detector.
// Clear, load and query requests pass through a two-entry queue to a search engine that
// owns the reference store. The engine carries out a clear or load in its idle state.
// A query reads the store through its single read port, one stored point per cycle,
// then drains the distance pipeline. Only a final query produces a result: it is loaded
// into the output register once that register is free. The user must write the touch
// limit through the configuration channel only while no request is in progress; the
// block does not enforce this. The store needs no clearing after reset.
module point_set_proximity_detector #(
    parameter int unsigned MAX_REFERENCE_POINTS = psp_pkg::MAX_REF_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  psp_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output psp_pkg::out_item_t            out_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [psp_pkg::DIST_BITS-1:0] cfg_data
);
    import psp_pkg::*;

    logic [DIST_BITS-1:0] touch_limit_reg;
    logic                 cmd_valid;
    logic                 cmd_ready;
    cmd_item_t            cmd_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_limit_reg <= TOUCH_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            touch_limit_reg <= cfg_data;
        end
    end

    psp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item)
    );

    psp_back #(
        .MAX_REFERENCE_POINTS (MAX_REFERENCE_POINTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_item    (cmd_item),
        .touch_limit (touch_limit_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

endmodule

// ===== bench/point_set_proximity_detector_tb.sv =====
// Self-checking testbench for the point set proximity detector with its own model.
module point_set_proximity_detector_tb;
    import psp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [DIST_BITS-1:0] CORNER_DIST = 34'd12884508675;
    localparam int RANDOM_REQUESTS = 520;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [DIST_BITS-1:0] cfg_data = '0;

    // model state
    point_t stored_pts[MAX_REF_DEFAULT];
    int stored_total = 0;
    logic [DIST_BITS-1:0] running_min = DIST_MAX;
    bit query_open = 1'b0;
    bit overflowed = 1'b0;
    logic [DIST_BITS-1:0] touch_limit = TOUCH_LIMIT_RESET;

    out_item_t pending_reports[$];
    out_item_t due_report;
    int error_count = 0;
    int requests_sent = 0;
    int reports_checked = 0;
    int limit_writes = 0;
    int send_calm = 0;
    int ready_calm = 0;

    point_set_proximity_detector dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [DIST_BITS-1:0] squared_gap(point_t p, in_item_t q);
        longint dx;
        longint dy;
        longint dz;
        longint s;
        dx = longint'($signed(p.x)) - longint'($signed(q.coord_x));
        dy = longint'($signed(p.y)) - longint'($signed(q.coord_y));
        dz = longint'($signed(p.z)) - longint'($signed(q.coord_z));
        s = dx * dx + dy * dy + dz * dz;
        if (s > longint'(DIST_MAX))
            s = longint'(DIST_MAX);
        return DIST_BITS'(s);
    endfunction

    function automatic void predict_request(in_item_t req);
        out_item_t rep;
        logic [DIST_BITS-1:0] d;
        case (req.operation)
            OP_CLEAR:
            begin
                stored_total = 0;
                overflowed = 1'b0;
                query_open = 1'b0;
                running_min = DIST_MAX;
            end
            OP_LOAD:
            begin
                if (stored_total < MAX_REF_DEFAULT)
                begin
                    stored_pts[stored_total] = {req.coord_x, req.coord_y, req.coord_z};
                    stored_total++;
                end
                else
                    overflowed = 1'b1;
            end
            OP_QUERY:
            begin
                query_open = 1'b1;
                for (int i = 0; i < stored_total; i++)
                begin
                    d = squared_gap(stored_pts[i], req);
                    if (d < running_min)
                        running_min = d;
                end
                if (req.final_query)
                begin
                    rep.store_overflowed = overflowed;
                    if (stored_total == 0 || !query_open)
                    begin
                        rep.touching = 1'b0;
                        rep.nearest_squared = DIST_MAX;
                        rep.set_empty = 1'b1;
                    end
                    else
                    begin
                        rep.touching = (running_min <= touch_limit);
                        rep.nearest_squared = running_min;
                        rep.set_empty = 1'b0;
                    end
                    pending_reports = {pending_reports, rep};
                    running_min = DIST_MAX;
                    query_open = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic in_item_t make_request(logic [1:0] op, int x, int y, int z, bit fin);
        in_item_t r;
        r.operation = op;
        r.coord_x = COORD_BITS'(x);
        r.coord_y = COORD_BITS'(y);
        r.coord_z = COORD_BITS'(z);
        r.final_query = fin;
        return r;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int near_coord(int centre, int spread);
        return centre + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic logic [DIST_BITS-1:0] random_limit();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return DIST_MAX;
            2: return DIST_BITS'($urandom_range(0, 400000));
            default: return {2'($urandom_range(0, 3)), 32'($urandom())};
        endcase
    endfunction

    function automatic void check_field(string what, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
            error_count++;
        end
    endfunction

    task automatic send_request(in_item_t req);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        do @(posedge clk); while (!in_ready);
        predict_request(req);
        requests_sent++;
    endtask

    task automatic send(logic [1:0] op, int x, int y, int z, bit fin);
        send_request(make_request(op, x, y, z, fin));
    endtask

    // wait for all reports, then long enough for the queue and engine to empty
    // with every request in flight scanning a full store
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat ((QUEUE_DEPTH + 1) * (MAX_REF_DEFAULT + 8)) @(posedge clk);
    endtask

    task automatic write_touch_limit(logic [DIST_BITS-1:0] value);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        touch_limit = value;
        limit_writes++;
    endtask

    task automatic test_empty_sets();
        send(OP_QUERY, 5, -5, 0, 1'b1);
        send(OP_QUERY, 0, 0, 0, 1'b0);
        send(OP_QUERY, -1, 1, -1, 1'b1);
        settle_block();
    endtask

    task automatic test_threshold_and_extremes();
        send(OP_CLEAR, 0, 0, 0, 1'b1);
        send(OP_LOAD, -32768, -32768, -32768, 1'b1);
        send(OP_UNUSED, 1, 1, 1, 1'b1);
        send(OP_QUERY, 32767, 32767, 32767, 1'b1);
        send(OP_LOAD, 32767, 32767, 32767, 1'b0);
        send(OP_QUERY, 32767, 32767, 32767, 1'b1);
        send(OP_CLEAR, 0, 0, 0, 1'b0);
        send(OP_LOAD, 0, 0, 0, 1'b0);
        send(OP_QUERY, 200, 0, 0, 1'b1);
        send(OP_QUERY, 0, -201, 0, 1'b1);
        send(OP_QUERY, -120, 160, 0, 1'b1);
        send(OP_QUERY, 1000, 0, 0, 1'b0);
        send(OP_QUERY, 5000, 5000, 5000, 1'b1);
        send(OP_QUERY, 5000, 5000, 5000, 1'b1);
        send(OP_CLEAR, 0, 0, 0, 1'b1);
        send(OP_QUERY, 7, 7, 7, 1'b1);
        settle_block();
    endtask

    task automatic test_touch_limit_settings();
        write_touch_limit('0);
        send(OP_CLEAR, 0, 0, 0, 1'b0);
        send(OP_LOAD, 10, -10, 10, 1'b0);
        send(OP_QUERY, 10, -10, 10, 1'b1);
        send(OP_QUERY, 11, -10, 10, 1'b1);
        write_touch_limit(CORNER_DIST);
        send(OP_CLEAR, 0, 0, 0, 1'b0);
        send(OP_LOAD, -32768, -32768, -32768, 1'b0);
        send(OP_QUERY, 32767, 32767, 32767, 1'b1);
        write_touch_limit(CORNER_DIST - 1);
        send(OP_QUERY, 32767, 32767, 32767, 1'b1);
        write_touch_limit(DIST_MAX);
        send(OP_QUERY, 32767, 32767, 32767, 1'b1);
        send(OP_CLEAR, 0, 0, 0, 1'b0);
        send(OP_QUERY, 32767, 32767, 32767, 1'b1);
        write_touch_limit(TOUCH_LIMIT_RESET);
    endtask

    task automatic test_random_traffic();
        int counted;
        int next_cfg;
        int n_refs;
        int n_queries;
        int cx;
        int cy;
        int cz;
        int spread;
        logic [1:0] op;
        counted = 0;
        next_cfg = 100;
        while (counted < RANDOM_REQUESTS)
        begin
            if (counted >= next_cfg)
            begin
                write_touch_limit(random_limit());
                next_cfg += 100 + $urandom_range(0, 40);
            end
            if ($urandom_range(0, 99) < 80)
            begin
                cx = any_coord();
                cy = any_coord();
                cz = any_coord();
                spread = ($urandom_range(0, 3) == 0) ? 150 : 600;
                if ($urandom_range(0, 99) < 75)
                begin
                    send(OP_CLEAR, any_coord(), any_coord(), any_coord(), $urandom_range(0, 1));
                    counted++;
                end
                n_refs = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                     : $urandom_range(0, 12);
                for (int i = 0; i < n_refs; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send(OP_LOAD, any_coord(), any_coord(), any_coord(),
                             $urandom_range(0, 1));
                    else
                        send(OP_LOAD, near_coord(cx, spread), near_coord(cy, spread),
                             near_coord(cz, spread), $urandom_range(0, 1));
                    counted++;
                end
                n_queries = $urandom_range(1, 5);
                for (int j = 0; j < n_queries; j++)
                begin
                    send(OP_QUERY, near_coord(cx, spread), near_coord(cy, spread),
                         near_coord(cz, spread), j == n_queries - 1);
                    counted++;
                end
            end
            else
            begin
                op = 2'($urandom_range(0, 3));
                send(op, any_coord(), any_coord(), any_coord(), $urandom_range(0, 1));
                if (op != OP_UNUSED)
                    counted++;
            end
        end
        settle_block();
    endtask

    // receiver back-pressure
    initial
    begin
        int stall;
        forever
        begin
            stall = pick_gap(ready_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t report with none due: touching %0d nearest %0d empty %0d ovf %0d",
                         $time, out_item.touching, out_item.nearest_squared,
                         out_item.set_empty, out_item.store_overflowed);
                error_count++;
            end
            else
            begin
                due_report = pending_reports.pop_front();
                check_field("touching", due_report.touching, out_item.touching);
                check_field("nearest_squared", due_report.nearest_squared,
                            out_item.nearest_squared);
                check_field("set_empty", due_report.set_empty, out_item.set_empty);
                check_field("store_overflowed", due_report.store_overflowed,
                            out_item.store_overflowed);
                reports_checked++;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_sets();
        test_threshold_and_extremes();
        test_touch_limit_settings();
        test_random_traffic();
        $display("%0d requests, %0d reports checked, %0d touch limit writes",
                 requests_sent, reports_checked, limit_writes);
        $display("covered empty sets, distance extremes, limit boundaries and random traffic");
        if (error_count == 0)
            $display("point_set_proximity_detector: match");
        else
            $display("point_set_proximity_detector: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d reports outstanding", pending_reports.size());
        $display("point_set_proximity_detector: mismatch");
        $finish;
    end

endmodule
